// File: hw/rtl/mfap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfap_pkg: shared types and constants for the max-flow block
// Request/result payloads, controller states and controller/datapath links.
// ----------------------------------------------------------------------------
package mfap_pkg;

	localparam int MAX_NODES     = 64;
	localparam int MAX_EDGES_DEF = 256;
	localparam int CAP_BITS      = 32;
	localparam int NODE_W        = 6;
	localparam int CNT_W         = 7;
	localparam int TOP_W         = $clog2(MAX_NODES + 1);
	localparam int IDX_W         = 8;
	localparam int TOTAL_W       = 40;

	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_RUN = 2'd1;
	localparam logic [1:0] CMD_CLR = 2'd2;

	localparam logic [1:0] ERR_OK   = 2'd0;
	localparam logic [1:0] ERR_NODE = 2'd1;
	localparam logic [1:0] ERR_FULL = 2'd2;

	localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;

	typedef struct packed {
		logic [1:0]          command;
		logic [NODE_W-1:0]   from_node;
		logic [NODE_W-1:0]   to_node;
		logic [31:0]         capacity;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0]    edge_index;
		logic [TOTAL_W-1:0]  total_flow;
		logic [1:0]          error;
	} rsp_t;

	typedef struct packed {
		logic [NODE_W-1:0]   tail;
		logic [NODE_W-1:0]   head;
		logic [CAP_BITS-1:0] cap;
	} edge_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECODE, ST_INIT, ST_SCAN_RD, ST_SCAN_EV, ST_POP_RD, ST_POP_LD,
		ST_SINK_WR, ST_BN_RD, ST_BN_ED, ST_BN_EV, ST_AUG_RD, ST_AUG_ED, ST_AUG_WR,
		ST_ADD_TOT, ST_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic decode;
		logic init;
		logic scan_rd;
		logic scan_ev;
		logic scan_step;
		logic push;
		logic pop_rd;
		logic pop_ld;
		logic sink_wr;
		logic bn_rd;
		logic bn_ed;
		logic bn_ev;
		logic aug_rd;
		logic aug_ed;
		logic aug_wr;
		logic add_tot;
	} cmd_t;

	typedef struct packed {
		logic go_search;
		logic scan_end;
		logic cand_ok;
		logic is_sink;
		logic top_zero;
		logic path_last;
	} stat_t;

endpackage

// File: hw/rtl/mfap_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfap_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mfap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: hw/rtl/mfap_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfap_ctrl: sequencer for the max-flow block
// Steps decode, depth-first scan, pop, bottleneck and augment passes.
// ----------------------------------------------------------------------------
module mfap_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  mfap_pkg::stat_t stat,
	output mfap_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           done
);
	mfap_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mfap_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			mfap_pkg::ST_IDLE:    if (start) state_nxt = mfap_pkg::ST_DECODE;
			mfap_pkg::ST_DECODE: begin
				state_nxt = stat.go_search ? mfap_pkg::ST_INIT : mfap_pkg::ST_RESP;
			end
			mfap_pkg::ST_INIT:    state_nxt = mfap_pkg::ST_SCAN_RD;
			mfap_pkg::ST_SCAN_RD: begin
				if (!stat.scan_end) begin
					state_nxt = mfap_pkg::ST_SCAN_EV;
				end else if (stat.top_zero) begin
					state_nxt = mfap_pkg::ST_RESP;
				end else begin
					state_nxt = mfap_pkg::ST_POP_RD;
				end
			end
			mfap_pkg::ST_SCAN_EV: begin
				if (stat.cand_ok && stat.is_sink) begin
					state_nxt = mfap_pkg::ST_SINK_WR;
				end else begin
					state_nxt = mfap_pkg::ST_SCAN_RD;
				end
			end
			mfap_pkg::ST_POP_RD:  state_nxt = mfap_pkg::ST_POP_LD;
			mfap_pkg::ST_POP_LD:  state_nxt = mfap_pkg::ST_SCAN_RD;
			mfap_pkg::ST_SINK_WR: state_nxt = mfap_pkg::ST_BN_RD;
			mfap_pkg::ST_BN_RD:   state_nxt = mfap_pkg::ST_BN_ED;
			mfap_pkg::ST_BN_ED:   state_nxt = mfap_pkg::ST_BN_EV;
			mfap_pkg::ST_BN_EV: begin
				state_nxt = stat.path_last ? mfap_pkg::ST_AUG_RD : mfap_pkg::ST_BN_RD;
			end
			mfap_pkg::ST_AUG_RD:  state_nxt = mfap_pkg::ST_AUG_ED;
			mfap_pkg::ST_AUG_ED:  state_nxt = mfap_pkg::ST_AUG_WR;
			mfap_pkg::ST_AUG_WR: begin
				state_nxt = stat.path_last ? mfap_pkg::ST_ADD_TOT : mfap_pkg::ST_AUG_RD;
			end
			mfap_pkg::ST_ADD_TOT: state_nxt = mfap_pkg::ST_INIT;
			mfap_pkg::ST_RESP:    state_nxt = mfap_pkg::ST_IDLE;
			default:              state_nxt = mfap_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			mfap_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			mfap_pkg::ST_DECODE:  cmd.decode  = 1'b1;
			mfap_pkg::ST_INIT:    cmd.init    = 1'b1;
			mfap_pkg::ST_SCAN_RD: cmd.scan_rd = 1'b1;
			mfap_pkg::ST_SCAN_EV: begin
				cmd.scan_ev   = 1'b1;
				cmd.push      = stat.cand_ok;
				cmd.scan_step = !stat.cand_ok;
			end
			mfap_pkg::ST_POP_RD:  cmd.pop_rd  = 1'b1;
			mfap_pkg::ST_POP_LD:  cmd.pop_ld  = 1'b1;
			mfap_pkg::ST_SINK_WR: cmd.sink_wr = 1'b1;
			mfap_pkg::ST_BN_RD:   cmd.bn_rd   = 1'b1;
			mfap_pkg::ST_BN_ED:   cmd.bn_ed   = 1'b1;
			mfap_pkg::ST_BN_EV:   cmd.bn_ev   = 1'b1;
			mfap_pkg::ST_AUG_RD:  cmd.aug_rd  = 1'b1;
			mfap_pkg::ST_AUG_ED:  cmd.aug_ed  = 1'b1;
			mfap_pkg::ST_AUG_WR:  cmd.aug_wr  = 1'b1;
			mfap_pkg::ST_ADD_TOT: cmd.add_tot = 1'b1;
			mfap_pkg::ST_RESP:    done        = 1'b1;
			default:              busy        = 1'b1;
		endcase
	end
endmodule

// File: hw/rtl/mfap_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfap_dpath: datapath for the max-flow block
// Edge table, flow table, frame stack, visited map and result registers.
// ----------------------------------------------------------------------------
module mfap_dpath #(
	parameter int MAX_EDGES = mfap_pkg::MAX_EDGES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mfap_pkg::req_t              request,
	input  logic                        cfg_we,
	input  logic [mfap_pkg::CNT_W-1:0]  cfg_data,
	input  mfap_pkg::cmd_t              cmd,
	output mfap_pkg::stat_t             stat,
	output mfap_pkg::rsp_t              result
);
	localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int UW = $clog2(MAX_EDGES + 1);
	localparam int PW = $clog2(2 * MAX_EDGES + 1);
	localparam int NW = mfap_pkg::NODE_W;
	localparam int TW = mfap_pkg::TOP_W;
	localparam int CW = mfap_pkg::CAP_BITS;
	localparam int FW = NW + PW + EW + 1;
	localparam int SD = mfap_pkg::MAX_NODES + 1;

	logic [mfap_pkg::CNT_W-1:0] node_count_q;
	logic [UW-1:0]              eu_q;
	mfap_pkg::req_t             req_q;
	mfap_pkg::rsp_t             rsp_q;
	logic [NW-1:0]              v_q;
	logic [PW-1:0]              p_q;
	logic [EW-1:0]              ein_q;
	logic                       bin_q;
	logic [TW-1:0]              top_q;
	logic [TW-1:0]              k_q;
	logic [CW-1:0]              bott_q;
	logic [EW-1:0]              e_q;
	logic                       back_q;
	logic [mfap_pkg::MAX_NODES-1:0] visited_q;

	// decode
	logic [mfap_pkg::CNT_W-1:0] lim;
	logic                       bad, full, add_ok;
	assign lim  = (node_count_q < mfap_pkg::CNT_W'(mfap_pkg::MAX_NODES)) ?
	              node_count_q : mfap_pkg::CNT_W'(mfap_pkg::MAX_NODES);
	assign bad  = ({1'b0, req_q.from_node} >= lim) || ({1'b0, req_q.to_node} >= lim);
	assign full = eu_q >= UW'(MAX_EDGES);
	assign add_ok = (req_q.command == mfap_pkg::CMD_ADD) && !bad && !full;

	// edge scan
	logic          p_back;
	logic [PW-1:0] idx_full;
	logic [EW-1:0] idx;
	assign p_back   = p_q >= PW'(eu_q);
	assign idx_full = p_back ? (p_q - PW'(eu_q)) : p_q;
	assign idx      = idx_full[EW-1:0];

	// memories
	mfap_pkg::edge_t er;
	logic [CW-1:0]   fr;
	logic [FW-1:0]   stk_rd, stk_wd;
	logic [EW-1:0]   stk_edge, erd_addr, f_waddr;
	logic            stk_back, f_we, stk_we;
	logic [TW-1:0]   stk_raddr;
	logic [CW-1:0]   f_wdata;
	mfap_pkg::edge_t ew;

	assign stk_back = stk_rd[0];
	assign stk_edge = stk_rd[EW:1];
	assign erd_addr = cmd.scan_rd ? idx : stk_edge;

	assign ew.tail = req_q.from_node;
	assign ew.head = req_q.to_node;
	assign ew.cap  = req_q.capacity[CW-1:0];

	assign f_we    = (cmd.decode && add_ok) || cmd.aug_wr;
	assign f_waddr = cmd.aug_wr ? e_q : EW'(eu_q);
	assign f_wdata = cmd.aug_wr ? (back_q ? (fr - bott_q) : (fr + bott_q)) : '0;

	// path walks read frame k, a pop reads the frame below the top
	assign stk_we    = cmd.push || cmd.sink_wr;
	assign stk_wd    = {v_q, (cmd.push ? (p_q + PW'(1)) : p_q), ein_q, bin_q};
	assign stk_raddr = (cmd.bn_rd || cmd.aug_rd) ? k_q : (top_q - TW'(1));

	mfap_ram #(.WIDTH($bits(mfap_pkg::edge_t)), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk   (clk),
		.we    (cmd.decode && add_ok),
		.waddr (EW'(eu_q)),
		.wdata (ew),
		.raddr (erd_addr),
		.rdata (er)
	);

	mfap_ram #(.WIDTH(CW), .DEPTH(MAX_EDGES)) u_flow_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.raddr (erd_addr),
		.rdata (fr)
	);

	mfap_ram #(.WIDTH(FW), .DEPTH(SD)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (top_q),
		.wdata (stk_wd),
		.raddr (stk_raddr),
		.rdata (stk_rd)
	);

	// residual of the edge just read
	logic          rback, match;
	logic [NW-1:0] other;
	logic [CW-1:0] res;
	assign rback = cmd.scan_ev ? p_back : back_q;
	assign res   = rback ? fr : (er.cap - fr);
	assign match = p_back ? (er.head == v_q) : (er.tail == v_q);
	assign other = p_back ? er.tail : er.head;

	logic [mfap_pkg::TOTAL_W:0] tot_sum;
	assign tot_sum = {1'b0, rsp_q.total_flow} + (mfap_pkg::TOTAL_W + 1)'(bott_q);

	assign stat.go_search = (req_q.command == mfap_pkg::CMD_RUN) && !bad &&
	                        (req_q.from_node != req_q.to_node);
	assign stat.scan_end  = p_q >= PW'({eu_q, 1'b0});
	assign stat.cand_ok   = match && !visited_q[other] && (res != '0);
	assign stat.is_sink   = other == req_q.to_node;
	assign stat.top_zero  = top_q == '0;
	assign stat.path_last = k_q == top_q;

	assign result = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= mfap_pkg::NODE_COUNT_RST;
			eu_q         <= '0;
		end else begin
			if (cfg_we) begin
				node_count_q <= cfg_data;
			end
			if (cmd.decode) begin
				if (add_ok) begin
					eu_q <= eu_q + UW'(1);
				end else if (req_q.command == mfap_pkg::CMD_CLR) begin
					eu_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= request;
			rsp_q <= '0;
		end
		if (cmd.decode) begin
			if ((req_q.command == mfap_pkg::CMD_ADD || req_q.command == mfap_pkg::CMD_RUN)
			    && bad) begin
				rsp_q.error <= mfap_pkg::ERR_NODE;
			end else if (req_q.command == mfap_pkg::CMD_ADD && full) begin
				rsp_q.error <= mfap_pkg::ERR_FULL;
			end else if (add_ok) begin
				rsp_q.edge_index <= mfap_pkg::IDX_W'(eu_q);
			end
		end
		if (cmd.init) begin
			visited_q <= {{(mfap_pkg::MAX_NODES-1){1'b0}}, 1'b1} << req_q.from_node;
			top_q     <= '0;
			v_q       <= req_q.from_node;
			p_q       <= '0;
		end
		if (cmd.scan_step) begin
			p_q <= p_q + PW'(1);
		end
		if (cmd.push) begin
			top_q            <= top_q + TW'(1);
			v_q              <= other;
			p_q              <= '0;
			ein_q            <= idx;
			bin_q            <= p_back;
			visited_q[other] <= 1'b1;
		end
		if (cmd.pop_rd) begin
			top_q <= top_q - TW'(1);
		end
		if (cmd.pop_ld) begin
			v_q   <= stk_rd[FW-1 -: NW];
			p_q   <= stk_rd[EW+PW:EW+1];
			ein_q <= stk_edge;
			bin_q <= stk_back;
		end
		if (cmd.sink_wr) begin
			k_q    <= TW'(1);
			bott_q <= '1;
		end
		if (cmd.bn_ed) begin
			back_q <= stk_back;
		end
		if (cmd.aug_ed) begin
			back_q <= stk_back;
			e_q    <= stk_edge;
		end
		if (cmd.bn_ev) begin
			if (res < bott_q) begin
				bott_q <= res;
			end
		end
		if (cmd.bn_ev || cmd.aug_wr) begin
			k_q <= stat.path_last ? TW'(1) : (k_q + TW'(1));
		end
		if (cmd.add_tot) begin
			rsp_q.total_flow <= tot_sum[mfap_pkg::TOTAL_W] ? '1 :
			                    tot_sum[mfap_pkg::TOTAL_W-1:0];
		end
	end
endmodule

// File: hw/rtl/max_flow_augmenting_path.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_flow_augmenting_path: Ford-Fulkerson max flow, depth-first search
// Busy until the done strobe; no output stall. Add, clear and no-search
// items go from decode to response. A compute item adds an init step per
// search, a scan read and evaluate per edge slot, a pop read and load per
// exhausted scan, and per path bottleneck and augment passes and a total add.
// Reset: node count 64, edge table empty. Table RAMs are not cleared.
// ----------------------------------------------------------------------------
module max_flow_augmenting_path #(
	parameter int MAX_EDGES = mfap_pkg::MAX_EDGES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  mfap_pkg::req_t             request,
	output logic                       done,
	output mfap_pkg::rsp_t             result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [mfap_pkg::CNT_W-1:0] cfg_data
);
	mfap_pkg::cmd_t  cmd;
	mfap_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	mfap_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mfap_dpath #(.MAX_EDGES(MAX_EDGES)) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.cfg_we   (cfg_valid),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.stat     (stat),
		.result   (result)
	);
endmodule

// File: hw/rtl/mfap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfap_checker: port-level checks for the max-flow block
// Item handshake sequencing and result consistency.
// ----------------------------------------------------------------------------
module mfap_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input mfap_pkg::rsp_t result
);
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done without busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted item not busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.error != mfap_pkg::ERR_OK) |->
		(result.total_flow == '0 && result.edge_index == '0))
		else $error("error result with nonzero fields");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.error == mfap_pkg::ERR_OK || result.error == mfap_pkg::ERR_NODE ||
		          result.error == mfap_pkg::ERR_FULL)) else $error("bad error code");
endmodule

bind max_flow_augmenting_path mfap_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
